// ----- hdl/urtb_pkg.sv -----
// Shared types and constants for the UART receive/transmit ring buffer block.
// No dependencies; used by uart_rx_tx_ring_buffers_core.
package urtb_pkg;

    localparam int DATA_W  = 8;
    localparam int CMD_W   = 2;
    localparam int CNT_W   = 16;
    localparam int FILL_W  = 4;

    // Request codes
    typedef enum logic [CMD_W-1:0] {
        CMD_RX_BYTE  = 2'd0,
        CMD_HOST_RD  = 2'd1,
        CMD_HOST_WR  = 2'd2,
        CMD_TX_READY = 2'd3
    } t_cmd;

endpackage

// ----- hdl/uart_rx_tx_ring_buffers_core.sv -----
// UART receive and transmit ring buffers, each store held in its own urtb_ram.
// Results appear in the cycle after the request is taken (the RAM read cycle).
// Throughput: one request per cycle while busy is low; busy is high in reset and the first cycle after it.
// Reset (synchronous, active low) empties both rings, clears the counters and the
// transmit request; ring contents are not cleared. Results cannot be stalled.
// Depends on urtb_pkg and urtb_ram.
module uart_rx_tx_ring_buffers_core #(
    parameter int RX_DEPTH = 16,
    parameter int TX_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [urtb_pkg::CMD_W-1:0]  i_cmd,
    input  logic [urtb_pkg::DATA_W-1:0] i_data,
    input  logic                        i_line_overrun,
    output logic                        o_done,
    output logic                        o_read_valid,
    output logic [urtb_pkg::DATA_W-1:0] o_read_data,
    output logic                        o_write_accepted,
    output logic                        o_send_valid,
    output logic [urtb_pkg::DATA_W-1:0] o_send_data,
    output logic                        o_send_request,
    output logic [urtb_pkg::FILL_W-1:0] o_rx_fill,
    output logic [urtb_pkg::CNT_W-1:0]  o_line_overrun_count,
    output logic [urtb_pkg::CNT_W-1:0]  o_drop_count
);

    localparam int RAW = $clog2(RX_DEPTH);
    localparam int TAW = $clog2(TX_DEPTH);
    localparam logic [RAW-1:0] RX_LAST = RAW'(RX_DEPTH - 1);
    localparam logic [TAW-1:0] TX_LAST = TAW'(TX_DEPTH - 1);
    localparam logic [RAW:0]   RX_SPAN = (RAW + 1)'(RX_DEPTH);

    // Pointers, counters and flags
    logic [RAW-1:0] r_rx_wr, n_rx_wr, r_rx_rd, n_rx_rd;
    logic [TAW-1:0] r_tx_wr, n_tx_wr, r_tx_rd, n_tx_rd;
    logic           r_tx_req, n_tx_req;
    logic [urtb_pkg::CNT_W-1:0] r_ovr_cnt, n_ovr_cnt, r_drop_cnt, n_drop_cnt;
    logic [urtb_pkg::FILL_W-1:0] r_fill, n_fill;
    logic r_done, r_rd_valid, n_rd_valid, r_wr_ok, n_wr_ok, r_snd_valid, n_snd_valid;
    logic r_busy;

    logic accept;
    urtb_pkg::t_cmd cmd;
    logic [RAW-1:0] rx_wr_next, rx_rd_next;
    logic [TAW-1:0] tx_wr_next, tx_rd_next;
    logic rx_full, rx_empty, tx_full, tx_empty;
    logic rx_we, rx_re, tx_we, tx_re;
    logic [RAW:0]  fill_raw;
    logic [urtb_pkg::DATA_W-1:0] rx_q, tx_q;

    assign accept = start && !busy;
    assign cmd    = urtb_pkg::t_cmd'(i_cmd);

    // Ring status
    assign rx_wr_next = (r_rx_wr == RX_LAST) ? '0 : r_rx_wr + 1'b1;
    assign rx_rd_next = (r_rx_rd == RX_LAST) ? '0 : r_rx_rd + 1'b1;
    assign tx_wr_next = (r_tx_wr == TX_LAST) ? '0 : r_tx_wr + 1'b1;
    assign tx_rd_next = (r_tx_rd == TX_LAST) ? '0 : r_tx_rd + 1'b1;
    assign rx_full    = (rx_wr_next == r_rx_rd);
    assign rx_empty   = (r_rx_rd == r_rx_wr);
    assign tx_full    = (tx_wr_next == r_tx_rd);
    assign tx_empty   = (r_tx_rd == r_tx_wr);

    // RAM strobes
    assign rx_we = accept && (cmd == urtb_pkg::CMD_RX_BYTE) && !rx_full;
    assign rx_re = accept && (cmd == urtb_pkg::CMD_HOST_RD) && !rx_empty;
    assign tx_we = accept && (cmd == urtb_pkg::CMD_HOST_WR) && !tx_full;
    assign tx_re = accept && (cmd == urtb_pkg::CMD_TX_READY) && !tx_empty;

    // Next state of pointers and counters
    always_comb begin
        n_rx_wr     = rx_we ? rx_wr_next : r_rx_wr;
        n_rx_rd     = rx_re ? rx_rd_next : r_rx_rd;
        n_tx_wr     = tx_we ? tx_wr_next : r_tx_wr;
        n_tx_rd     = tx_re ? tx_rd_next : r_tx_rd;
        n_ovr_cnt   = r_ovr_cnt;
        n_drop_cnt  = r_drop_cnt;
        n_tx_req    = r_tx_req;
        n_rd_valid  = rx_re;
        n_wr_ok     = tx_we;
        n_snd_valid = tx_re;
        if (accept) begin
            unique case (cmd)
                urtb_pkg::CMD_RX_BYTE: begin
                    if (i_line_overrun) begin
                        n_ovr_cnt = r_ovr_cnt + 1'b1;
                    end
                    if (rx_full) begin
                        n_drop_cnt = r_drop_cnt + 1'b1;
                    end
                end
                urtb_pkg::CMD_HOST_WR: begin
                    if (!tx_full) begin
                        n_tx_req = 1'b1;
                    end
                end
                urtb_pkg::CMD_TX_READY: begin
                    if (n_tx_rd == r_tx_wr) begin
                        n_tx_req = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Receive fill after this request, truncated to the result width
    assign fill_raw = (n_rx_wr >= n_rx_rd)
                      ? {1'b0, n_rx_wr} - {1'b0, n_rx_rd}
                      : {1'b0, n_rx_wr} + RX_SPAN - {1'b0, n_rx_rd};
    assign n_fill   = urtb_pkg::FILL_W'(fill_raw);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_wr     <= '0;
            r_rx_rd     <= '0;
            r_tx_wr     <= '0;
            r_tx_rd     <= '0;
            r_tx_req    <= 1'b0;
            r_ovr_cnt   <= '0;
            r_drop_cnt  <= '0;
            r_fill      <= '0;
            r_done      <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_wr_ok     <= 1'b0;
            r_snd_valid <= 1'b0;
            r_busy      <= 1'b1;
        end else begin
            r_rx_wr     <= n_rx_wr;
            r_rx_rd     <= n_rx_rd;
            r_tx_wr     <= n_tx_wr;
            r_tx_rd     <= n_tx_rd;
            r_tx_req    <= n_tx_req;
            r_ovr_cnt   <= n_ovr_cnt;
            r_drop_cnt  <= n_drop_cnt;
            r_fill      <= accept ? n_fill : r_fill;
            r_done      <= accept;
            r_rd_valid  <= n_rd_valid;
            r_wr_ok     <= n_wr_ok;
            r_snd_valid <= n_snd_valid;
            r_busy      <= 1'b0;
        end
    end

    // Ring stores
    urtb_ram #(.WIDTH(urtb_pkg::DATA_W), .DEPTH(RX_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_wr),
        .i_wdata (i_data),
        .i_re    (rx_re),
        .i_raddr (r_rx_rd),
        .o_rdata (rx_q)
    );

    urtb_ram #(.WIDTH(urtb_pkg::DATA_W), .DEPTH(TX_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_wr),
        .i_wdata (i_data),
        .i_re    (tx_re),
        .i_raddr (r_tx_rd),
        .o_rdata (tx_q)
    );

    // Result ports
    assign busy                 = r_busy;
    assign o_done               = r_done;
    assign o_read_valid         = r_rd_valid;
    assign o_read_data          = r_rd_valid ? rx_q : '0;
    assign o_write_accepted     = r_wr_ok;
    assign o_send_valid         = r_snd_valid;
    assign o_send_data          = r_snd_valid ? tx_q : '0;
    assign o_send_request       = r_tx_req;
    assign o_rx_fill            = r_fill;
    assign o_line_overrun_count = r_ovr_cnt;
    assign o_drop_count         = r_drop_cnt;

    // Checks
    a_done_follows_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("result strobe missing after a request");

    a_flags_need_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_read_valid || o_write_accepted || o_send_valid) |-> o_done)
        else $error("result flag without a result strobe");

    a_write_sets_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_write_accepted |-> o_send_request)
        else $error("accepted write did not raise the transmit request");

    a_drop_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drop_cnt != $past(r_drop_cnt)) |-> ($past(rx_full) && $past(rx_we) == 1'b0))
        else $error("drop counted while the receive ring had room");

endmodule

// ----- hdl/urtb_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read data.
// Depends on nothing; instanced for each ring store.
module urtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
